// ===== rtl/core/dfiir_pkg.sv =====
// shared types and constants for the direct-form iir filter core
`default_nettype none

package dfiir_pkg;

  localparam int CHANNELS = 2;
  localparam int MAX_TAPS = 16;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TAP_W  = $clog2(MAX_TAPS);
  localparam int LEN_W  = $clog2(MAX_TAPS + 1);
  localparam int MEM_AW = 1 + CH_W + TAP_W;

  localparam int SAMPLE_W = 32;
  localparam int COEF_W   = 32;
  localparam int HIST_W   = 48;
  localparam int ACC_W    = 64;
  localparam int GAIN_W   = 16;
  localparam int CNT_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_SHIFT = 24;
  localparam int OUT_SHIFT  = 31;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'h8000;

  localparam logic signed [SAMPLE_W-1:0] LIM16_LO = -32'sd32768;
  localparam logic signed [SAMPLE_W-1:0] LIM16_HI = 32'sd32767;
  localparam logic signed [SAMPLE_W-1:0] LIM32_LO = 32'sh8000_0000;
  localparam logic signed [SAMPLE_W-1:0] LIM32_HI = 32'sh7fff_ffff;

  typedef enum logic [1:0] {
    KIND_SAMPLE    = 2'd0,
    KIND_NUM_TAP   = 2'd1,
    KIND_DEN_TAP   = 2'd2,
    KIND_FRAME_END = 2'd3
  } item_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRE_GAIN  = 3'd0,
    REG_POST_GAIN = 3'd1,
    REG_NUM_LEN   = 3'd2,
    REG_DEN_LEN   = 3'd3,
    REG_FORMAT    = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_RUN,
    S_DRAIN,
    S_POST,
    S_DONE
  } fsm_state_t;

  typedef struct packed {
    logic vld;
    logic sub;
  } mac_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/dfiir_ram.sv =====
// synchronous ram with one write port, one registered read port and per-entry valid bits
`default_nettype none

module dfiir_ram #(
  parameter int AW = 6,
  parameter int DW = 48
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DW-1:0]    rd_mem_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_mem_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // unwritten entries read as zero
  assign rd_data = rd_vld_r ? rd_mem_r : '0;

endmodule

`default_nettype wire

// ===== rtl/core/dfiir_mac.sv =====
// pipelined tap multiply-accumulate with 48-bit saturated sum
`default_nettype none

module dfiir_mac
  import dfiir_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mac_ctl_t                 issue,
  input  wire logic                     clear,
  input  wire logic signed [COEF_W-1:0] coef,
  input  wire logic signed [HIST_W-1:0] hist,
  output logic                          busy,
  output logic signed [HIST_W-1:0]      sum
);

  localparam int HI_W  = HIST_W - FRAC_SHIFT;
  localparam int PHI_W = COEF_W + HI_W;
  localparam int PLO_W = COEF_W + FRAC_SHIFT + 1;

  mac_ctl_t s0_r, sa_r, sb_r;

  logic signed [PHI_W-1:0] p_hi_w, p_hi_r;
  logic signed [PLO_W-1:0] p_lo_w, p_lo_r;
  logic signed [ACC_W-1:0] term_r;
  logic signed [ACC_W-1:0] acc_r;

  // tap * h split as tap * floor(h / 2^24) and tap * (h mod 2^24)
  assign p_hi_w = $signed(coef) * $signed(hist[HIST_W-1:FRAC_SHIFT]);
  assign p_lo_w = $signed(coef) * $signed({1'b0, hist[FRAC_SHIFT-1:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r <= '0;
      sa_r <= '0;
      sb_r <= '0;
    end else begin
      s0_r <= issue;
      sa_r <= s0_r;
      sb_r <= sa_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_r.vld) begin
      p_hi_r <= p_hi_w;
      p_lo_r <= p_lo_w;
    end
    if (sa_r.vld) begin
      term_r <= {{(ACC_W-PHI_W){p_hi_r[PHI_W-1]}}, p_hi_r}
              + {{(ACC_W-PLO_W+FRAC_SHIFT){p_lo_r[PLO_W-1]}}, p_lo_r[PLO_W-1:FRAC_SHIFT]};
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      acc_r <= '0;
    end else if (sb_r.vld) begin
      acc_r <= sb_r.sub ? acc_r - term_r : acc_r + term_r;
    end
  end

  assign busy = s0_r.vld | sa_r.vld | sb_r.vld;

  always_comb begin
    if ((&acc_r[ACC_W-1:HIST_W-1]) || !(|acc_r[ACC_W-1:HIST_W-1])) begin
      sum = acc_r[HIST_W-1:0];
    end else begin
      sum = {acc_r[ACC_W-1], {(HIST_W-1){~acc_r[ACC_W-1]}}};
    end
  end

  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clear |-> !busy && !issue.vld)
    else $error("accumulator cleared with taps in flight");

endmodule

`default_nettype wire

// ===== rtl/core/dfiir_post.sv =====
// wet gain scaling and output saturation
`default_nettype none

module dfiir_post
  import dfiir_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic signed [HIST_W-1:0]   sum,
  input  wire logic        [GAIN_W-1:0]   gain,
  input  wire logic                       fmt,
  output logic                            done,
  output logic signed [SAMPLE_W-1:0]      y,
  output logic                            clip
);

  localparam int FULL_W = HIST_W + GAIN_W + 2;

  logic [GAIN_W-1:0]        g;
  logic signed [FULL_W-1:0] v_full;
  logic signed [ACC_W-1:0]  v_r;
  logic                     fmt_r;
  logic                     v_vld_r;
  logic                     done_r;

  logic signed [SAMPLE_W-1:0] lo_lim, hi_lim;
  logic signed [ACC_W-1:0]    lo_v, hi_v;
  logic signed [SAMPLE_W-1:0] q;
  logic signed [SAMPLE_W-1:0] y_r;
  logic                       clip_r;

  assign g      = (gain > GAIN_UNITY) ? GAIN_UNITY : gain;
  assign v_full = $signed(sum) * $signed({1'b0, g});

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= v_full[ACC_W-1:0];
      fmt_r <= fmt;
    end
  end

  always_comb begin
    lo_lim = fmt_r ? LIM32_LO : LIM16_LO;
    hi_lim = fmt_r ? LIM32_HI : LIM16_HI;
    lo_v   = {lo_lim[SAMPLE_W-1], lo_lim, {OUT_SHIFT{1'b0}}};
    hi_v   = {hi_lim[SAMPLE_W-1], hi_lim, {OUT_SHIFT{1'b0}}};
    // round toward zero
    q = v_r[OUT_SHIFT+SAMPLE_W-1:OUT_SHIFT];
    if (v_r[ACC_W-1] && (|v_r[OUT_SHIFT-1:0])) begin
      q = q + 32'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (v_vld_r) begin
      if (v_r < lo_v) begin
        y_r    <= lo_lim;
        clip_r <= 1'b1;
      end else if (v_r > hi_v) begin
        y_r    <= hi_lim;
        clip_r <= 1'b1;
      end else begin
        y_r    <= q;
        clip_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_vld_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      v_vld_r <= start;
      done_r  <= v_vld_r;
    end
  end

  assign done = done_r;
  assign y    = y_r;
  assign clip = clip_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !v_vld_r && !done_r)
    else $error("post stage restarted while busy");

endmodule

`default_nettype wire

// ===== rtl/core/direct_form_iir_filter_core.sv =====
// top level of the multichannel direct-form iir filter core
`default_nettype none

// Multichannel direct-form I IIR filter. Sample beats (kind 0) are scaled by the
// dry gain, pushed into the channel's input history and filtered with up to 16
// numerator and 15 feedback taps; the sum goes to the output history, is scaled
// by the wet gain and saturated to 16 or 32 bits. A sample beat runs one tap per
// cycle through a single shared multiply-accumulate pipeline fed by the history
// and coefficient memories, then the accumulate drain and the registered output
// stage. Tap loads give no result; a frame-end beat returns and clears the
// channel's clip count. Results sit in an output register, and a new beat is
// accepted while a result waits there. Memories come out of reset reading as
// zero with no clearing pass. Configuration must be written only when idle;
// the block itself does not enforce this.

module direct_form_iir_filter_core
  import dfiir_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_kind,
  input  wire logic                  in_channel,
  input  wire logic signed [31:0]    in_sample_in,
  input  wire logic [3:0]            in_tap_index,
  input  wire logic signed [31:0]    in_tap_value,

  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_channel_out,
  output logic signed [31:0]         out_sample_out,
  output logic                       out_clipped,
  output logic [15:0]                out_clip_count,

  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wdata
);

  fsm_state_t state_r, state_nxt;

  logic [GAIN_W-1:0] pre_gain_r, post_gain_r;
  logic [4:0]        num_len_r, den_len_r;
  logic              fmt_r;

  item_kind_t                 kind_r;
  logic [CH_W-1:0]            ch_r;
  logic signed [SAMPLE_W-1:0] smp_r;
  logic [TAP_W-1:0]           p_r;
  logic [TAP_W-1:0]           k_r, k_nxt;
  logic                       den_r, den_nxt;

  logic [TAP_W-1:0] hist_ptr_r [CHANNELS];
  logic [CNT_W-1:0] clip_cnt_r [CHANNELS];

  logic                   out_valid_r;
  logic                   out_channel_r;
  logic [SAMPLE_W-1:0]    out_sample_r;
  logic                   out_clipped_r;
  logic [CNT_W-1:0]       out_count_r;

  item_kind_t       in_kind_e;
  logic             in_fire;
  logic             ch_ok;
  logic             tap_ok;
  logic [LEN_W-1:0] nb, na;
  logic [TAP_W-1:0] p_new;
  logic [TAP_W:0]   idx_sum;
  logic [TAP_W-1:0] idx;
  logic             last_tap;
  logic [GAIN_W-1:0] dry_g;
  logic signed [SAMPLE_W+GAIN_W:0] x_prod;
  logic [HIST_W-1:0] xs;
  logic              push;
  logic              commit;

  logic              hist_we;
  logic [MEM_AW-1:0] hist_waddr;
  logic [HIST_W-1:0] hist_wdata;
  logic [MEM_AW-1:0] hist_raddr;
  logic [HIST_W-1:0] hist_rdata;
  logic              coef_we;
  logic [MEM_AW-1:0] coef_waddr;
  logic [MEM_AW-1:0] coef_raddr;
  logic [COEF_W-1:0] coef_rdata;
  logic              rd_en;

  mac_ctl_t                   mac_issue;
  logic                       mac_clear;
  logic                       mac_busy;
  logic signed [HIST_W-1:0]   mac_sum;
  logic                       post_start;
  logic                       post_done;
  logic signed [SAMPLE_W-1:0] post_y;
  logic                       post_clip;
  logic [CNT_W-1:0]           cnt_cur;
  logic [CNT_W-1:0]           cnt_inc;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_kind_e = item_kind_t'(in_kind);
  assign ch_ok     = int'(in_channel) < CHANNELS;
  assign tap_ok    = int'(in_tap_index) < MAX_TAPS;

  assign nb = (int'(num_len_r) > MAX_TAPS) ? LEN_W'(MAX_TAPS) : LEN_W'(num_len_r);
  assign na = (int'(den_len_r) > MAX_TAPS) ? LEN_W'(MAX_TAPS) : LEN_W'(den_len_r);

  assign p_new = (hist_ptr_r[ch_r] == '0) ? TAP_W'(MAX_TAPS - 1)
                                           : hist_ptr_r[ch_r] - TAP_W'(1);

  always_comb begin
    idx_sum = (TAP_W+1)'(p_r) + (TAP_W+1)'(k_r);
    if (int'(idx_sum) >= MAX_TAPS) begin
      idx_sum = idx_sum - (TAP_W+1)'(MAX_TAPS);
    end
    idx = idx_sum[TAP_W-1:0];
  end

  assign last_tap = den_r ? ((LEN_W'(k_r) + LEN_W'(1)) == na)
                          : ((LEN_W'(k_r) + LEN_W'(1)) == nb);

  assign dry_g  = (pre_gain_r > GAIN_UNITY) ? GAIN_UNITY : pre_gain_r;
  assign x_prod = $signed(smp_r) * $signed({1'b0, dry_g});
  assign xs     = {x_prod[HIST_W-2:0], 1'b0};

  assign hist_raddr = {den_r, ch_r, idx};
  assign coef_raddr = {den_r, ch_r, k_r};
  assign coef_we    = in_fire && ch_ok && tap_ok &&
                      (in_kind_e == KIND_NUM_TAP || in_kind_e == KIND_DEN_TAP);
  assign coef_waddr = {(in_kind_e == KIND_DEN_TAP), CH_W'(in_channel), TAP_W'(in_tap_index)};

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    den_nxt    = den_r;
    hist_we    = 1'b0;
    hist_waddr = '0;
    hist_wdata = '0;
    rd_en      = 1'b0;
    mac_issue  = '0;
    mac_clear  = 1'b0;
    post_start = 1'b0;
    push       = 1'b0;
    commit     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && ch_ok) begin
          unique case (in_kind_e)
            KIND_SAMPLE:    state_nxt = S_PUSH;
            KIND_FRAME_END: state_nxt = S_DONE;
            KIND_NUM_TAP:   state_nxt = S_IDLE;
            KIND_DEN_TAP:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_PUSH: begin
        hist_we    = 1'b1;
        hist_waddr = {1'b0, ch_r, p_new};
        hist_wdata = xs;
        mac_clear  = 1'b1;
        push       = 1'b1;
        if (nb != '0) begin
          state_nxt = S_RUN;
          k_nxt     = '0;
          den_nxt   = 1'b0;
        end else if (na > LEN_W'(1)) begin
          state_nxt = S_RUN;
          k_nxt     = TAP_W'(1);
          den_nxt   = 1'b1;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_RUN: begin
        rd_en         = 1'b1;
        mac_issue.vld = 1'b1;
        mac_issue.sub = den_r;
        if (last_tap) begin
          if (!den_r && na > LEN_W'(1)) begin
            k_nxt   = TAP_W'(1);
            den_nxt = 1'b1;
          end else begin
            state_nxt = S_DRAIN;
          end
        end else begin
          k_nxt = k_r + TAP_W'(1);
        end
      end
      S_DRAIN: begin
        if (!mac_busy) begin
          hist_we    = 1'b1;
          hist_waddr = {1'b1, ch_r, p_r};
          hist_wdata = mac_sum;
          post_start = 1'b1;
          state_nxt  = S_POST;
        end
      end
      S_POST: begin
        if (post_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          commit    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      den_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      den_r   <= den_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_gain_r  <= GAIN_UNITY;
      post_gain_r <= GAIN_UNITY;
      num_len_r   <= 5'd2;
      den_len_r   <= 5'd2;
      fmt_r       <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PRE_GAIN:  pre_gain_r  <= cfg_wdata;
        REG_POST_GAIN: post_gain_r <= cfg_wdata;
        REG_NUM_LEN:   num_len_r   <= cfg_wdata[4:0];
        REG_DEN_LEN:   den_len_r   <= cfg_wdata[4:0];
        REG_FORMAT:    fmt_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_kind_e;
      ch_r   <= CH_W'(in_channel);
      smp_r  <= in_sample_in;
    end
    if (push) begin
      p_r <= p_new;
    end
  end

  assign cnt_cur = clip_cnt_r[ch_r];
  assign cnt_inc = (post_clip && cnt_cur != '1) ? cnt_cur + CNT_W'(1) : cnt_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        hist_ptr_r[c] <= '0;
        clip_cnt_r[c] <= '0;
      end
    end else begin
      if (push) begin
        hist_ptr_r[ch_r] <= p_new;
      end
      if (commit) begin
        clip_cnt_r[ch_r] <= (kind_r == KIND_FRAME_END) ? '0 : cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_channel_r <= 1'(ch_r);
      if (kind_r == KIND_FRAME_END) begin
        out_sample_r  <= '0;
        out_clipped_r <= 1'b0;
        out_count_r   <= cnt_cur;
      end else begin
        out_sample_r  <= post_y;
        out_clipped_r <= post_clip;
        out_count_r   <= cnt_inc;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel_out = out_channel_r;
  assign out_sample_out  = out_sample_r;
  assign out_clipped     = out_clipped_r;
  assign out_clip_count  = out_count_r;

  dfiir_ram #(
    .AW (MEM_AW),
    .DW (HIST_W)
  ) u_hist_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (hist_we),
    .wr_addr (hist_waddr),
    .wr_data (hist_wdata),
    .rd_en   (rd_en),
    .rd_addr (hist_raddr),
    .rd_data (hist_rdata)
  );

  dfiir_ram #(
    .AW (MEM_AW),
    .DW (COEF_W)
  ) u_coef_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (coef_we),
    .wr_addr (coef_waddr),
    .wr_data (in_tap_value),
    .rd_en   (rd_en),
    .rd_addr (coef_raddr),
    .rd_data (coef_rdata)
  );

  dfiir_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (mac_issue),
    .clear (mac_clear),
    .coef  (coef_rdata),
    .hist  (hist_rdata),
    .busy  (mac_busy),
    .sum   (mac_sum)
  );

  dfiir_post u_post (
    .clk   (clk),
    .rst_n (rst_n),
    .start (post_start),
    .sum   (mac_sum),
    .gain  (post_gain_r),
    .fmt   (fmt_r),
    .done  (post_done),
    .y     (post_y),
    .clip  (post_clip)
  );

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !mac_busy)
    else $error("beat accepted with taps still in the accumulator");

  a_post_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    post_done |-> state_r == S_POST)
    else $error("output stage finished outside its wait state");

  a_clip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> out_sample_out != '0)
    else $error("clipped beat carries a zero sample");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// self-checking testbench for the direct-form iir filter core
`timescale 1ns / 1ps

module tb
  import dfiir_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int PHASES         = 8;
  localparam int PHASE_BEATS    = 80;
  localparam longint HIST_HI    = 64'sh0000_7fff_ffff_ffff;
  localparam longint HIST_LO    = -HIST_HI - 1;
  localparam longint OUT_SCALE  = 64'sd2147483648;
  localparam longint GAIN_CAP   = 64'sd32768;

  typedef struct packed {
    item_kind_t         kind;
    logic               ch;
    logic signed [31:0] sample;
    logic [3:0]         tidx;
    logic signed [31:0] tval;
  } filter_item_t;

  typedef struct packed {
    logic               ch;
    logic signed [31:0] sample;
    logic               clipped;
    logic [15:0]        count;
  } filter_result_t;

  typedef struct packed {
    filter_item_t   it;
    logic           typed;
    filter_result_t res;
  } stim_row_t;

  localparam filter_result_t NO_RES = '0;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_kind = KIND_SAMPLE;
  logic                 in_channel = 1'b0;
  logic signed [31:0]   in_sample_in = '0;
  logic [3:0]           in_tap_index = '0;
  logic signed [31:0]   in_tap_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_channel_out;
  logic signed [31:0]   out_sample_out;
  logic                 out_clipped;
  logic [15:0]          out_clip_count;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  direct_form_iir_filter_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_channel      (in_channel),
    .in_sample_in    (in_sample_in),
    .in_tap_index    (in_tap_index),
    .in_tap_value    (in_tap_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel_out (out_channel_out),
    .out_sample_out  (out_sample_out),
    .out_clipped     (out_clipped),
    .out_clip_count  (out_clip_count),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // filter state as the block should hold it
  logic signed [47:0] x_hist [2][16];
  logic signed [47:0] y_hist [2][16];
  logic signed [31:0] num_taps [2][16];
  logic signed [31:0] den_taps [2][16];
  logic [3:0]         newest [2];
  logic [15:0]        clip_tally [2];
  logic [15:0]        pre_gain, post_gain;
  logic [4:0]         num_len, den_len;
  logic               wide_out;

  filter_result_t awaited_results [$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  quiet = 1'b0;

  function automatic longint tap_product(logic signed [31:0] tap, logic signed [47:0] h);
    logic signed [79:0] prod;
    prod = tap * h;
    return longint'(prod >>> FRAC_SHIFT);
  endfunction

  task automatic filter_step(input filter_item_t it, output bit has_res,
                             output filter_result_t res);
    logic [3:0] p, idx;
    longint     g, acc, v, lo_lim, hi_lim, y;
    int         nb, na;
    bit         clip;
    has_res = 1'b0;
    res = '0;
    clip = 1'b0;
    case (it.kind)
      KIND_NUM_TAP: num_taps[it.ch][it.tidx] = it.tval;
      KIND_DEN_TAP: den_taps[it.ch][it.tidx] = it.tval;
      KIND_FRAME_END: begin
        has_res = 1'b1;
        res = '{it.ch, 32'sd0, 1'b0, clip_tally[it.ch]};
        clip_tally[it.ch] = '0;
      end
      default: begin
        p = newest[it.ch] - 4'd1;
        newest[it.ch] = p;
        g = (pre_gain > 16'd32768) ? GAIN_CAP : longint'(pre_gain);
        x_hist[it.ch][p] = 48'(longint'(it.sample) * g * 2);
        acc = 0;
        nb = (num_len > 5'd16) ? 16 : int'(num_len);
        na = (den_len > 5'd16) ? 16 : int'(den_len);
        for (int k = 0; k < nb; k++) begin
          idx = 4'(p + k);
          acc += tap_product(num_taps[it.ch][k], x_hist[it.ch][idx]);
        end
        for (int k = 1; k < na; k++) begin
          idx = 4'(p + k);
          acc -= tap_product(den_taps[it.ch][k], y_hist[it.ch][idx]);
        end
        if (acc > HIST_HI) acc = HIST_HI;
        if (acc < HIST_LO) acc = HIST_LO;
        y_hist[it.ch][p] = acc[47:0];
        g = (post_gain > 16'd32768) ? GAIN_CAP : longint'(post_gain);
        v = acc * g;
        lo_lim = wide_out ? longint'(LIM32_LO) : longint'(LIM16_LO);
        hi_lim = wide_out ? longint'(LIM32_HI) : longint'(LIM16_HI);
        if (v < lo_lim * OUT_SCALE) begin
          y = lo_lim;
          clip = 1'b1;
        end else if (v > hi_lim * OUT_SCALE) begin
          y = hi_lim;
          clip = 1'b1;
        end else begin
          y = v / OUT_SCALE;
        end
        if (clip && clip_tally[it.ch] != 16'hffff) clip_tally[it.ch]++;
        has_res = 1'b1;
        res = '{it.ch, y[31:0], clip, clip_tally[it.ch]};
      end
    endcase
  endtask

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("%0t: %s got %0h, want %0h", $time, field, got, want);
    mismatches++;
  endtask

  // result side: checking and random stalls
  always @(posedge clk) begin
    filter_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result beat, channel", out_channel_out, 0);
        end else begin
          want = awaited_results.pop_front();
          if (out_channel_out !== want.ch)
            report_mismatch("channel_out", out_channel_out, want.ch);
          if (out_sample_out !== want.sample)
            report_mismatch("sample_out", out_sample_out, want.sample);
          if (out_clipped !== want.clipped)
            report_mismatch("clipped", out_clipped, want.clipped);
          if (out_clip_count !== want.count)
            report_mismatch("clip_count", out_clip_count, want.count);
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= (stall_left == 1);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall_left <= $urandom_range(1, 5);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("direct_form_iir_filter_core: mismatch");
        $finish;
      end
    end
  end

  task automatic send_beat(input filter_item_t it, input bit typed, input filter_result_t typed_res);
    bit             has_res;
    filter_result_t res;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= it.kind;
    in_channel   <= it.ch;
    in_sample_in <= it.sample;
    in_tap_index <= it.tidx;
    in_tap_value <= it.tval;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    filter_step(it, has_res, res);
    if (has_res) awaited_results.push_back(typed ? typed_res : res);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [15:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_PRE_GAIN:  pre_gain = data;
      REG_POST_GAIN: post_gain = data;
      REG_NUM_LEN:   num_len = data[4:0];
      REG_DEN_LEN:   den_len = data[4:0];
      default:       wide_out = data[0];
    endcase
    @(posedge clk);
  endtask

  function automatic filter_item_t random_item();
    filter_item_t       it;
    logic signed [15:0] s16;
    int                 pick;
    it = '0;
    it.ch = 1'($urandom_range(0, 1));
    it.tidx = 4'($urandom_range(0, 15));
    it.sample = $urandom;
    it.tval = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      it.kind = KIND_SAMPLE;
      case ($urandom_range(0, 9))
        0: it.sample = $urandom;
        1: begin
          case ($urandom_range(0, 5))
            0: it.sample = LIM32_LO;
            1: it.sample = LIM32_HI;
            2: it.sample = LIM16_LO;
            3: it.sample = LIM16_HI;
            4: it.sample = 32'sd0;
            default: it.sample = -32'sd1;
          endcase
        end
        2, 3: it.sample = int'($urandom_range(0, 512)) - 256;
        default: begin
          s16 = 16'($urandom);
          it.sample = s16;
        end
      endcase
    end else if (pick < 85) begin
      it.kind = ($urandom_range(0, 1) == 0) ? KIND_NUM_TAP : KIND_DEN_TAP;
      case ($urandom_range(0, 5))
        0: it.tval = $urandom;
        1: it.tval = ($urandom_range(0, 1) == 0) ? 32'sh0100_0000 : -32'sh0100_0000;
        default:
          if (it.kind == KIND_NUM_TAP)
            it.tval = int'($urandom_range(0, 1 << 25)) - (1 << 24);
          else
            it.tval = int'($urandom_range(0, 1 << 21)) - (1 << 20);
      endcase
    end else begin
      it.kind = KIND_FRAME_END;
    end
    return it;
  endfunction

  // reset defaults; rows with a typed result rely on all taps being zero
  stim_row_t directed_rows [20] = '{
    '{'{KIND_SAMPLE,    1'b0, 32'sh7fff_ffff, 4'd0,  32'sd0},         1'b1,
      '{1'b0, 32'sd0, 1'b0, 16'd0}},
    '{'{KIND_SAMPLE,    1'b1, 32'sh8000_0000, 4'd0,  32'sd0},         1'b1,
      '{1'b1, 32'sd0, 1'b0, 16'd0}},
    '{'{KIND_FRAME_END, 1'b0, 32'sd0,         4'd0,  32'sd0},         1'b1,
      '{1'b0, 32'sd0, 1'b0, 16'd0}},
    '{'{KIND_NUM_TAP,   1'b0, 32'sd0,         4'd0,  32'sh0100_0000}, 1'b0, NO_RES},
    '{'{KIND_NUM_TAP,   1'b0, 32'sd0,         4'd15, 32'sh7fff_ffff}, 1'b0, NO_RES},
    '{'{KIND_NUM_TAP,   1'b0, 32'sd0,         4'd1,  32'sh8000_0000}, 1'b0, NO_RES},
    '{'{KIND_DEN_TAP,   1'b0, 32'sd0,         4'd1,  32'sh0080_0000}, 1'b0, NO_RES},
    '{'{KIND_DEN_TAP,   1'b0, 32'sd0,         4'd0,  32'sh7fff_ffff}, 1'b0, NO_RES},
    '{'{KIND_SAMPLE,    1'b0, 32'sh7fff_ffff, 4'd0,  32'sd0},         1'b0, NO_RES},
    '{'{KIND_SAMPLE,    1'b0, 32'sh8000_0000, 4'd0,  32'sd0},         1'b0, NO_RES},
    '{'{KIND_SAMPLE,    1'b0, 32'sd0,         4'd0,  32'sd0},         1'b0, NO_RES},
    '{'{KIND_SAMPLE,    1'b0, 32'sd100,       4'd0,  32'sd0},         1'b0, NO_RES},
    '{'{KIND_FRAME_END, 1'b0, 32'sd0,         4'd0,  32'sd0},         1'b0, NO_RES},
    '{'{KIND_NUM_TAP,   1'b1, 32'sd0,         4'd0,  32'sh0100_0000}, 1'b0, NO_RES},
    '{'{KIND_DEN_TAP,   1'b1, 32'sd0,         4'd15, 32'sh8000_0000}, 1'b0, NO_RES},
    '{'{KIND_SAMPLE,    1'b1, -32'sd32768,    4'd0,  32'sd0},         1'b0, NO_RES},
    '{'{KIND_SAMPLE,    1'b1, 32'sd32767,     4'd0,  32'sd0},         1'b0, NO_RES},
    '{'{KIND_SAMPLE,    1'b1, -32'sd1,        4'd0,  32'sd0},         1'b0, NO_RES},
    '{'{KIND_FRAME_END, 1'b1, 32'sd0,         4'd0,  32'sd0},         1'b0, NO_RES},
    '{'{KIND_FRAME_END, 1'b0, 32'sd0,         4'd0,  32'sd0},         1'b0, NO_RES}
  };

  initial begin
    logic [15:0] dry, wet;
    logic [4:0]  nlen, dlen;
    logic        fmt;
    for (int c = 0; c < 2; c++) begin
      for (int t = 0; t < 16; t++) begin
        x_hist[c][t] = '0;
        y_hist[c][t] = '0;
        num_taps[c][t] = '0;
        den_taps[c][t] = '0;
      end
      newest[c] = '0;
      clip_tally[c] = '0;
    end
    pre_gain = GAIN_UNITY;
    post_gain = GAIN_UNITY;
    num_len = 5'd2;
    den_len = 5'd2;
    wide_out = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].res);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin dry = 16'd32768; wet = 16'd32768; nlen = 5'd16; dlen = 5'd16; fmt = 1'b1; end
        1: begin dry = 16'd0;     wet = 16'hffff;  nlen = 5'd31; dlen = 5'd0;  fmt = 1'b0; end
        2: begin dry = 16'hffff;  wet = 16'd0;     nlen = 5'd0;  dlen = 5'd1;  fmt = 1'b1; end
        3: begin dry = 16'd1;     wet = 16'd1;     nlen = 5'd1;  dlen = 5'd31; fmt = 1'b1; end
        PHASES - 1: begin
          dry = 16'd32768; wet = 16'd16384; nlen = 5'd8; dlen = 5'd4; fmt = 1'b0;
        end
        default: begin
          dry  = 16'($urandom_range(0, 40000));
          wet  = 16'($urandom_range(0, 40000));
          nlen = 5'($urandom_range(0, 31));
          dlen = 5'($urandom_range(0, 31));
          fmt  = 1'($urandom_range(0, 1));
        end
      endcase
      cfg_write(REG_PRE_GAIN, dry);
      cfg_write(REG_POST_GAIN, wet);
      cfg_write(REG_NUM_LEN, {11'd0, nlen});
      cfg_write(REG_DEN_LEN, {11'd0, dlen});
      cfg_write(REG_FORMAT, {15'd0, fmt});
      cfg_wr_en <= 1'b0;
      quiet = (ph == PHASES - 1);
      for (int i = 0; i < PHASE_BEATS; i++)
        send_beat(random_item(), 1'b0, NO_RES);
    end

    settle();
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("direct_form_iir_filter_core: match");
    end else begin
      $display("direct_form_iir_filter_core: mismatch");
    end
    $finish;
  end

endmodule
